/* rtl/core/salc_pkg.sv */
// Package for the set-associative LRU cache tag model.
// Holds payload structs, register indexes and fixed constants; no dependencies.
package salc_pkg;

	localparam int ADDR_W = 32;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way_used;
		logic        evict_dirty;
		logic [31:0] access_count;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] writeback_count;
	} rsp_t;

	typedef enum logic [1:0] {
		REG_OFFSET = 2'd0,
		REG_INDEX  = 2'd1,
		REG_WAYS   = 2'd2
	} reg_idx_t;

	localparam logic [1:0] FUNC_WRITE = 2'd1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

endpackage

/* rtl/core/salc_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/set_assoc_lru_cache_model.sv */
// Set-associative write-back cache tag model with LRU replacement. Uses salc_pkg, salc_ram.
// After reset a clearing pass writes every set row (busy high) before any word is
// accepted. For each access the set row is read from memory at the accepting edge, then
// compared and written back in the following cycle. The result strobe is high in the
// cycle after that, with busy already low, so the next start can be taken at the edge
// that ends the strobe cycle. The receiver cannot stall.
module set_assoc_lru_cache_model
	import salc_pkg::*;
#(
	parameter int MAX_SETS = 1024,
	parameter int MAX_WAYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ROW_W = MAX_WAYS * (ADDR_W + 2 + WW);

	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic              valid;
		logic              dirty;
		logic [WW-1:0]     rank;  // 0 = most recent
	} way_t;

	logic [3:0] off_q, idx_q, ways_q;
	state_t state_q;
	logic [SW-1:0] clr_q, set_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic wr_s1;
	logic [31:0] acc_q, hit_q, miss_q, wb_q;

	logic we;
	logic [SW-1:0] waddr, raddr;
	logic [ROW_W-1:0] wrow, rrow;
	way_t rd [MAX_WAYS];
	way_t wr [MAX_WAYS];

	salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(rrow)
	);

	// config port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[3:2])
			REG_OFFSET: prdata = {28'd0, off_q};
			REG_INDEX:  prdata = {28'd0, idx_q};
			REG_WAYS:   prdata = {28'd0, ways_q};
			default:    prdata = '0;
		endcase
	end

	// effective split
	logic [4:0] ib, ob;
	logic [4:0] nw;
	logic [ADDR_W-1:0] sh;
	always_comb begin
		ib = {1'b0, idx_q};
		if ((1 << idx_q) > MAX_SETS) ib = 5'(IB_MAX);
		if (MAX_SETS == 1) ib = 5'd0;
		ob = {1'b0, off_q};
		nw = (ways_q == 4'd0) ? 5'd1 : {1'b0, ways_q};
		if (nw > 5'(MAX_WAYS)) nw = 5'(MAX_WAYS);
		sh = req.address >> ob;
	end

	logic acc;
	assign busy = (state_q != ST_IDLE);
	assign acc = start && !busy;
	assign raddr = SW'(sh & ((ADDR_W'(1) << ib) - ADDR_W'(1)));

	// unpack row
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			rd[w] = rrow[w*$bits(way_t) +: $bits(way_t)];
		end
	end

	// lookup and replacement
	logic hit;
	logic [WW-1:0] hway, iway, lway, way, vrank;
	logic ifound, evict;
	always_comb begin
		hit = 1'b0; hway = '0; ifound = 1'b0; iway = '0; lway = '0;
		for (int w = MAX_WAYS-1; w >= 0; w--) begin
			if (w < nw && rd[w].valid && rd[w].tag == tag_s1) begin
				hit = 1'b1; hway = WW'(w);
			end
			if (w < nw && !rd[w].valid) begin
				ifound = 1'b1; iway = WW'(w);
			end
		end
		// least recent among the ways in use: highest rank
		vrank = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < nw && rd[w].rank >= vrank) begin
				vrank = rd[w].rank; lway = WW'(w);
			end
		end
		way = hit ? hway : (ifound ? iway : lway);
		evict = !hit && !ifound && rd[lway].dirty;
		for (int w = 0; w < MAX_WAYS; w++) begin
			wr[w] = rd[w];
			if (rd[w].rank < rd[way].rank) wr[w].rank = rd[w].rank + WW'(1);
			if (WW'(w) == way) begin
				wr[w].rank = '0;
				if (!hit) begin
					wr[w].tag = tag_s1; wr[w].valid = 1'b1; wr[w].dirty = 1'b0;
				end
				if (wr_s1) wr[w].dirty = 1'b1;
			end
		end
	end

	// write port: clearing pass or write back
	always_comb begin
		we = 1'b0; waddr = set_s1; wrow = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1; waddr = clr_q;
			for (int w = 0; w < MAX_WAYS; w++) begin
				wrow[w*$bits(way_t) +: $bits(way_t)] = {{ADDR_W{1'b0}}, 2'b00, WW'(w)};
			end
		end else if (state_q == ST_LOOK) begin
			we = 1'b1;
			for (int w = 0; w < MAX_WAYS; w++) begin
				wrow[w*$bits(way_t) +: $bits(way_t)] = wr[w];
			end
		end
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0;
			off_q <= 4'd5; idx_q <= 4'd6; ways_q <= 4'd4;
			acc_q <= '0; hit_q <= '0; miss_q <= '0; wb_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_OFFSET: off_q <= pwdata[3:0];
					REG_INDEX:  idx_q <= pwdata[3:0];
					REG_WAYS:   ways_q <= pwdata[3:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(MAX_SETS-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc) state_q <= ST_LOOK;
				ST_LOOK: begin
					state_q <= ST_IDLE; done <= 1'b1;
					acc_q <= acc_q + 32'd1;
					if (hit) hit_q <= hit_q + 32'd1;
					else miss_q <= miss_q + 32'd1;
					if (evict) wb_q <= wb_q + 32'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// access stage and result register
	always_ff @(posedge clk) begin
		if (acc) begin
			set_s1 <= raddr;
			tag_s1 <= sh >> ib;
			wr_s1 <= (req.func == FUNC_WRITE);
		end
		if (state_q == ST_LOOK) begin
			rsp.hit <= hit;
			rsp.way_used <= 3'(way);
			rsp.evict_dirty <= evict;
			rsp.access_count <= acc_q + 32'd1;
			rsp.hit_count <= hit ? hit_q + 32'd1 : hit_q;
			rsp.miss_count <= hit ? miss_q : miss_q + 32'd1;
			rsp.writeback_count <= evict ? wb_q + 32'd1 : wb_q;
		end
	end
endmodule

/* rtl/core/salc_checker.sv */
// Port-level checker for the cache tag model; bound to the top level.
// Uses salc_pkg.
module salc_checker
	import salc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp,
	input logic pready
);
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done) else $error("missing result");
	a_busy_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy during lookup");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.access_count == rsp.hit_count + rsp.miss_count)
		else $error("count mismatch");
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.evict_dirty) |-> !rsp.hit) else $error("evict on hit");
	a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind set_assoc_lru_cache_model salc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp), .pready(pready)
);

/* sim/set_assoc_lru_cache_model_tb.sv */
// Self-checking bench for the set-associative LRU cache tag model.
// Predicts every lookup in a local cache image; depends on salc_pkg and the block's RTL.
module set_assoc_lru_cache_model_tb;
	import salc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSETS = 1024;
	localparam int NWAYS = 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	set_assoc_lru_cache_model u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: cache image and settings
	logic [31:0] img_tag [NSETS*NWAYS];
	bit          img_valid [NSETS*NWAYS];
	bit          img_dirty [NSETS*NWAYS];
	logic [2:0]  img_order [NSETS][NWAYS];
	logic [31:0] n_acc, n_hit, n_miss, n_wb;
	logic [3:0]  cfg_offset, cfg_index, cfg_ways;

	req_t pending_words [$];
	rsp_t expected_rsps [$];
	int   errors;
	int   idle_pct;
	bit   hold_off;
	int   accepted;
	int   checked;

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = 1'b1;
			#2 clk = 1'b0;
		end
	end

	// move way to the most recent slot of its set
	function automatic void promote(int s, logic [2:0] w);
		int p;
		p = 0;
		while (p < NWAYS-1 && img_order[s][p] != w)
			p++;
		for (int k = p; k > 0; k--)
			img_order[s][k] = img_order[s][k-1];
		img_order[s][0] = w;
	endfunction

	// compute one lookup and advance the image
	function automatic rsp_t lookup_predict(req_t r);
		rsp_t o;
		int nw, ib, s, base, way;
		logic [63:0] a, tg;
		bit hit, found, ev;
		nw = cfg_ways;
		if (nw == 0) nw = 1;
		if (nw > NWAYS) nw = NWAYS;
		ib = cfg_index;
		while (ib > 0 && (1 << ib) > NSETS) ib--;
		a = {32'd0, r.address};
		s = int'((a >> cfg_offset) & ((64'd1 << ib) - 1));
		tg = a >> (cfg_offset + ib);
		base = s * NWAYS;
		hit = 0; found = 0; ev = 0; way = 0;
		n_acc++;
		for (int w = 0; w < nw; w++)
			if (!hit && img_valid[base+w] && {32'd0, img_tag[base+w]} == tg) begin
				hit = 1;
				way = w;
			end
		if (hit) begin
			n_hit++;
		end else begin
			n_miss++;
			for (int w = 0; w < nw; w++)
				if (!found && !img_valid[base+w]) begin
					found = 1;
					way = w;
				end
			if (!found) begin
				for (int p = NWAYS-1; p >= 0; p--)
					if (!found && img_order[s][p] < nw) begin
						found = 1;
						way = img_order[s][p];
					end
				if (img_dirty[base+way]) begin
					ev = 1;
					n_wb++;
				end
			end
			img_valid[base+way] = 1;
			img_tag[base+way] = tg[31:0];
			img_dirty[base+way] = 0;
		end
		if (r.func == FUNC_WRITE)
			img_dirty[base+way] = 1;
		promote(s, way[2:0]);
		o.hit = hit;
		o.way_used = way[2:0];
		o.evict_dirty = ev;
		o.access_count = n_acc;
		o.hit_count = n_hit;
		o.miss_count = n_miss;
		o.writeback_count = n_wb;
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
		errors++;
	endtask

	// driver: hand one word per accept, with random idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				expected_rsps.push_back(lookup_predict(req));
				accepted++;
			end
			if (start && busy) begin
				// hold the word
			end else if (!hold_off && pending_words.size() > 0
				&& $urandom_range(99) >= idle_pct) begin
				req <= pending_words.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			rsp_t e;
			if (expected_rsps.size() == 0) begin
				$display("unexpected result word");
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.hit !== e.hit) report("hit", rsp.hit, e.hit);
				if (rsp.way_used !== e.way_used) report("way_used", rsp.way_used, e.way_used);
				if (rsp.evict_dirty !== e.evict_dirty)
					report("evict_dirty", rsp.evict_dirty, e.evict_dirty);
				if (rsp.access_count !== e.access_count)
					report("access_count", rsp.access_count, e.access_count);
				if (rsp.hit_count !== e.hit_count) report("hit_count", rsp.hit_count, e.hit_count);
				if (rsp.miss_count !== e.miss_count)
					report("miss_count", rsp.miss_count, e.miss_count);
				if (rsp.writeback_count !== e.writeback_count)
					report("writeback_count", rsp.writeback_count, e.writeback_count);
			end
			checked++;
		end
	end

	// wait until every queued word is taken and answered
	task automatic drain();
		while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write in setup and access phases
	task automatic reg_write(reg_idx_t idx, logic [3:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {28'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_OFFSET: cfg_offset = val;
			REG_INDEX:  cfg_index = val;
			default:    cfg_ways = val;
		endcase
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
		drain();
		reg_write(REG_OFFSET, ob);
		reg_write(REG_INDEX, ib);
		reg_write(REG_WAYS, nw);
	endtask

	function automatic req_t mk(logic [1:0] f, logic [31:0] a);
		req_t r;
		r.func = f;
		r.address = a;
		return r;
	endfunction

	// random word biased to a small working set so hits and evictions occur
	function automatic req_t rnd_word();
		logic [31:0] a;
		if ($urandom_range(9) < 8)
			a = ($urandom_range(15) << 16) | ($urandom_range(7) << 5) | $urandom_range(31);
		else
			a = $urandom();
		if ($urandom_range(15) == 0) a = ~a;
		return mk(2'($urandom_range(3)), a);
	endfunction

	task automatic burst(int n, int pct);
		idle_pct = pct;
		repeat (n) pending_words.push_back(rnd_word());
	endtask

	initial begin
		errors = 0; accepted = 0; checked = 0;
		idle_pct = 0; hold_off = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		cfg_offset = 5; cfg_index = 6; cfg_ways = 4;
		n_acc = 0; n_hit = 0; n_miss = 0; n_wb = 0;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			img_tag[i] = '0; img_valid[i] = 0; img_dirty[i] = 0;
		end
		for (int s = 0; s < NSETS; s++)
			for (int w = 0; w < NWAYS; w++)
				img_order[s][w] = w[2:0];
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: every kind, extreme addresses, fill then evict one set
		pending_words.push_back(mk(2'd0, 32'h0000_0000));
		pending_words.push_back(mk(2'd1, 32'hFFFF_FFFF));
		pending_words.push_back(mk(2'd2, 32'hFFFF_FFFF));
		pending_words.push_back(mk(2'd3, 32'h0000_0000));
		for (int t = 0; t < 6; t++)
			pending_words.push_back(mk(2'd1, (t << 11) | 32'h40));
		for (int t = 0; t < 6; t++)
			pending_words.push_back(mk(2'd0, (t << 11) | 32'h40));
		pending_words.push_back(mk(2'd3, 32'h5555_5555));
		pending_words.push_back(mk(2'd2, 32'hAAAA_AAAA));
		drain();

		// geometry extremes: zero ways, oversize ways and index, wide offset
		set_geometry(0, 0, 0);
		burst(40, 0);
		set_geometry(15, 15, 15);
		burst(50, 54);
		// pause mid-burst until all answers are in, then resume
		repeat (30) @(posedge clk);
		hold_off = 1;
		while (start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		hold_off = 0;
		set_geometry(12, 10, 8);
		burst(60, 14);
		set_geometry(5, 3, 2);
		burst(80, 0);
		set_geometry(4, 10, 1);
		burst(60, 54);
		set_geometry(5, 2, 8);
		burst(100, 14);
		set_geometry(0, 1, 9);
		burst(60, 0);
		set_geometry(5, 6, 4);
		burst(50, 54);
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d lookups over eight geometries, %0d results checked",
			accepted, checked);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
